FILE: rtl/bedpu_pkg.sv
`timescale 1ns / 1ps

package bedpu_pkg;

    // Width of the core's operand and result registers
    localparam int FIELD_BITS = 32;

    // Operation codes
    typedef enum logic [1:0] {
        FN_EXTRACT = 2'd0,
        FN_DEPOSIT = 2'd1,
        FN_BITREV  = 2'd2,
        FN_BYTEREV = 2'd3
    } t_func;

    typedef logic [3:0] t_nibble;

    // Mirror of a 4-bit nibble
    localparam t_nibble NIB_MIRROR [16] = '{
        4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
        4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
    };

endpackage

FILE: rtl/bit_extract_deposit_permute_unit_core.sv
`timescale 1ns / 1ps
// A word accepted (start high, busy low) passes the input register and
// the result register, then is on o_result_value with o_done, for one cycle.
// Throughput: one word per cycle; busy stays low, the input and result
// registers form a two-stage pipeline. The result cannot be stalled.
// Reset: synchronous, active low; clears the stage valid flags only.

module bit_extract_deposit_permute_unit_core #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_source_value,
    input  logic [31:0] i_bit_mask,
    output logic        busy,
    output logic        o_done,
    output logic [31:0] o_result_value
);

    localparam int FB = bedpu_pkg::FIELD_BITS;

    logic                  r_in_vld;
    bedpu_pkg::t_func      r_func;
    logic [FB-1:0]         r_src;
    logic [FB-1:0]         r_mask;
    logic                  r_done;
    logic [FB-1:0]         r_result;
    logic [WORD_BITS-1:0]  w_src;
    logic [WORD_BITS-1:0]  w_mask;
    logic [WORD_BITS-1:0]  w_result;
    logic [FB-1:0]         n_result;

    // never held off: a new word every cycle
    assign busy = 1'b0;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_func <= bedpu_pkg::t_func'(i_func);
            r_src  <= i_source_value;
            r_mask <= i_bit_mask;
        end
    end

    // fit the port word to the operating width
    genvar g;
    generate
        for (g = 0; g < WORD_BITS; g++) begin : g_in_fit
            if (g < FB) begin : g_bit
                assign w_src[g]  = r_src[g];
                assign w_mask[g] = r_mask[g];
            end else begin : g_zero
                assign w_src[g]  = 1'b0;
                assign w_mask[g] = 1'b0;
            end
        end
        for (g = 0; g < FB; g++) begin : g_out_fit
            if (g < WORD_BITS) begin : g_bit
                assign n_result[g] = w_result[g];
            end else begin : g_zero
                assign n_result[g] = 1'b0;
            end
        end
    endgenerate

    bedpu_permute #(
        .WORD_BITS (WORD_BITS)
    ) u_permute (
        .i_func         (r_func),
        .i_source_value (w_src),
        .i_bit_mask     (w_mask),
        .o_result_value (w_result)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_done         = r_done;
    assign o_result_value = r_result;

    // every accepted word is delivered with o_done
    a_accept_to_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted word not delivered");

    // no result strobe without an accepted word before it
    a_done_has_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without accepted word");

    // empty mask gives zero for extract and deposit
    a_empty_mask : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_bit_mask == '0)
         && ((i_func == bedpu_pkg::FN_EXTRACT) || (i_func == bedpu_pkg::FN_DEPOSIT)))
        |=> ##1 (o_result_value == '0))
        else $error("non-zero result for empty mask");

endmodule

FILE: rtl/bedpu_permute.sv
`timescale 1ns / 1ps

// Combinational permute datapath: extract, deposit, bit and byte reverse
module bedpu_permute #(
    parameter int WORD_BITS = 32
) (
    input  bedpu_pkg::t_func       i_func,
    input  logic [WORD_BITS-1:0]   i_source_value,
    input  logic [WORD_BITS-1:0]   i_bit_mask,
    output logic [WORD_BITS-1:0]   o_result_value
);

    localparam int IW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int NB = WORD_BITS / 8;

    logic [IW-1:0]        rank [WORD_BITS];
    logic [WORD_BITS-1:0] ext_word;
    logic [WORD_BITS-1:0] dep_word;
    logic [WORD_BITS-1:0] bitrev_word;
    logic [WORD_BITS-1:0] byterev_word;

    // rank of each mask bit: number of set mask bits below it
    always_comb begin
        logic [WORD_BITS-1:0] below;
        for (int i = 0; i < WORD_BITS; i++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                below[j] = (j < i);
            end
            rank[i] = IW'($countones(i_bit_mask & below));
        end
    end

    // extract: result bit k takes the source bit whose mask rank is k
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            ext_word[k] = 1'b0;
            for (int i = 0; i < WORD_BITS; i++) begin
                ext_word[k] = ext_word[k]
                            | (i_bit_mask[i] & i_source_value[i] & (rank[i] == IW'(k)));
            end
        end
    end

    // deposit: mask bit i takes the source bit at its rank
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            dep_word[i] = i_bit_mask[i] & i_source_value[rank[i]];
        end
    end

    // reverses over whole bytes; bits above them stay zero
    always_comb begin
        logic [7:0] b;
        bitrev_word  = '0;
        byterev_word = '0;
        for (int n = 0; n < NB; n++) begin
            b = i_source_value[8*n +: 8];
            byterev_word[8*(NB-1-n) +: 8] = b;
            bitrev_word[8*(NB-1-n) +: 8]  = {bedpu_pkg::NIB_MIRROR[b[3:0]],
                                             bedpu_pkg::NIB_MIRROR[b[7:4]]};
        end
    end

    // operation select
    always_comb begin
        unique case (i_func)
            bedpu_pkg::FN_EXTRACT: o_result_value = ext_word;
            bedpu_pkg::FN_DEPOSIT: o_result_value = dep_word;
            bedpu_pkg::FN_BITREV:  o_result_value = bitrev_word;
            bedpu_pkg::FN_BYTEREV: o_result_value = byterev_word;
            default:               o_result_value = '0;
        endcase
    end

endmodule
